>>> sv/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/pdist_pkg.sv
// shared types and constants for the 2d distance pipeline
package pdist_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // control bits that travel with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } pdist_ctl_t;

endpackage

>>> sv/pdist_skid.sv
// input skid buffer that decouples s_tready from the pipeline stall
module pdist_skid #(
  parameter int W = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [W-1:0]           in_data,
  input  logic                   in_last,
  input  logic                   ce,
  output pdist_pkg::pdist_ctl_t  out_ctl,
  output logic [W-1:0]           out_data
);
  import pdist_pkg::*;

  logic         skid_full;
  logic [W-1:0] skid_data;
  logic         skid_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (ce) begin
      skid_full <= 1'b0;
    end else if (in_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  // holds the item taken while the pipeline was stalled
  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_data <= in_data;
      skid_last <= in_last;
    end
  end

  assign in_ready      = !skid_full;
  assign out_ctl.valid = skid_full || in_valid;
  assign out_ctl.last  = skid_full ? skid_last : in_last;
  assign out_data      = skid_full ? skid_data : in_data;

endmodule

>>> sv/pdist_sumsq.sv
// three stages: absolute differences, squares, sum of squares
module pdist_sumsq #(
  parameter int CW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  pdist_pkg::pdist_ctl_t  ctl_in,
  input  logic signed [CW-1:0]   ax,
  input  logic signed [CW-1:0]   ay,
  input  logic signed [CW-1:0]   bx,
  input  logic signed [CW-1:0]   by,
  output pdist_pkg::pdist_ctl_t  ctl_out,
  output logic [2*CW+1:0]        sum
);
  import pdist_pkg::*;

  localparam int DW = CW + 1;
  localparam int SW = 2 * CW + 2;

  pdist_ctl_t      ctl1, ctl2;
  logic [CW:0]     dx_raw, dy_raw;
  logic [DW-1:0]   adx, ady;
  logic [SW-1:0]   sqx, sqy;

  // exact differences in one extra bit
  assign dx_raw = {ax[CW-1], ax} - {bx[CW-1], bx};
  assign dy_raw = {ay[CW-1], ay} - {by[CW-1], by};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl_out <= '0;
    end else if (ce) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl_out <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // magnitude up to 2^CW-1 fits unsigned in CW+1 bits
      adx <= dx_raw[CW] ? (~dx_raw + 1'b1) : dx_raw;
      ady <= dy_raw[CW] ? (~dy_raw + 1'b1) : dy_raw;
      sqx <= SW'(adx * adx);
      sqy <= SW'(ady * ady);
      sum <= sqx + sqy;
    end
  end

endmodule

>>> sv/pdist_root_step.sv
// one restoring square-root stage, one root bit per stage
module pdist_root_step #(
  parameter int CW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ce,
  input  pdist_pkg::pdist_ctl_t  ctl_in,
  input  logic [2*CW+1:0]        rad_in,
  input  logic [CW+2:0]          rem_in,
  input  logic [CW:0]            root_in,
  output pdist_pkg::pdist_ctl_t  ctl_out,
  output logic [2*CW+1:0]        rad_out,
  output logic [CW+2:0]          rem_out,
  output logic [CW:0]            root_out
);
  import pdist_pkg::*;

  localparam int RW = CW + 1;
  localparam int SW = 2 * CW + 2;
  localparam int MW = RW + 2;

  logic [MW+1:0] rem_sh, trial, diff;
  logic          take;

  assign rem_sh = {rem_in, rad_in[SW-1:SW-2]};
  assign trial  = {2'b00, root_in, 2'b01};
  assign diff   = rem_sh - trial;
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (ce) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rad_out  <= rad_in << 2;
      rem_out  <= take ? diff[MW-1:0] : rem_sh[MW-1:0];
      root_out <= {root_in[RW-2:0], take};
    end
  end

endmodule

>>> sv/pythagorean_distance_2d_unit.sv
// top level of the pipelined 2d euclidean distance unit
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready     | s_tdata: first_x, first_y, second_x,
//          |     |                         |   second_y; s_tlast: last_in
//  m_      | out | m_tvalid / m_tready     | m_tdata: distance; m_tlast: last_out
//
// one item per cycle sustained unless m_tready stalls; the pipeline depth comes from
// the sum of squares stages and the square root that resolves one root bit per stage
// rst (synchronous) clears every valid bit and the skid flag; data is not cleared
// a stall on m_tready freezes the whole pipeline; the final root stage is the
// output register, and a one-item skid buffer keeps s_tready registered
// nothing is dropped or repeated across stalls
module pythagorean_distance_2d_unit #(
  parameter int COORD_WIDTH = pdist_pkg::COORD_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // first_x, first_y, second_x, second_y (lowest bit up), zero padded
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
  input  logic                                    s_tlast,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // distance, zero padded
  output logic [((COORD_WIDTH+1+7)/8)*8-1:0]      m_tdata,
  output logic                                    m_tlast
);
  import pdist_pkg::*;
`include "assert_macros.svh"

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;          // distance / root width
  localparam int SW    = 2 * CW + 2;      // sum of squares width
  localparam int MW    = DW + 2;          // remainder width
  localparam int PW    = 4 * CW;          // packed coordinates
  localparam int OUT_W = ((DW + 7) / 8) * 8;

  // global stall: the pipeline moves when the output register is free or taken
  logic ce;
  assign ce = !m_tvalid || m_tready;

  pdist_ctl_t      front_ctl;
  logic [PW-1:0]   front_data;

  pdist_skid #(.W(PW)) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata[PW-1:0]),
    .in_last  (s_tlast),
    .ce       (ce),
    .out_ctl  (front_ctl),
    .out_data (front_data)
  );

  // square root pipeline taps, index 0 is the sum of squares
  pdist_ctl_t    ctl_p  [0:DW];
  logic [SW-1:0] rad_p  [0:DW];
  logic [MW-1:0] rem_p  [0:DW];
  logic [DW-1:0] root_p [0:DW];

  pdist_sumsq #(.CW(CW)) u_sumsq (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .ctl_in  (front_ctl),
    .ax      (front_data[CW-1:0]),
    .ay      (front_data[2*CW-1:CW]),
    .bx      (front_data[3*CW-1:2*CW]),
    .by      (front_data[4*CW-1:3*CW]),
    .ctl_out (ctl_p[0]),
    .sum     (rad_p[0])
  );

  assign rem_p[0]  = '0;
  assign root_p[0] = '0;

  for (genvar k = 0; k < DW; k++) begin : g_root
    pdist_root_step #(.CW(CW)) u_step (
      .clk      (clk),
      .rst      (rst),
      .ce       (ce),
      .ctl_in   (ctl_p[k]),
      .rad_in   (rad_p[k]),
      .rem_in   (rem_p[k]),
      .root_in  (root_p[k]),
      .ctl_out  (ctl_p[k+1]),
      .rad_out  (rad_p[k+1]),
      .rem_out  (rem_p[k+1]),
      .root_out (root_p[k+1])
    );
  end

  // last root stage doubles as the output register
  assign m_tvalid = ctl_p[DW].valid;
  assign m_tlast  = ctl_p[DW].last;
  assign m_tdata  = OUT_W'(root_p[DW]);

  // final remainder never exceeds twice the root
  `ASSERT_IMPL(a_rem_bound, clk, rst, m_tvalid, rem_p[DW] <= {root_p[DW], 1'b0})
  // skid holds an item only after a stalled cycle
  `ASSERT_IMPL(a_skid_after_stall, clk, rst, !s_tready, $past(!ce))
  // a held item stays held while the stall lasts
  `ASSERT_NEXT(a_skid_keeps, clk, rst, !s_tready && !ce, !s_tready)

endmodule
